// ----- hw/rtl/interval_endpoint_event_sorter_defines.svh -----
// Assertion macros used by the checker file.
`ifndef INTERVAL_ENDPOINT_EVENT_SORTER_DEFINES_SVH
`define INTERVAL_ENDPOINT_EVENT_SORTER_DEFINES_SVH

// ante at one edge implies cons at the next edge
`define IEPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ieps assertion failed");

// ante at one edge implies cons at the same edge
`define IEPS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ieps assertion failed");

`endif

// ----- hw/rtl/ieps_pkg.sv -----
// Types and constants of the interval endpoint event sorter.
package ieps_pkg;

   localparam int MAX_EVENTS     = 512;
   localparam int TIME_BITS      = 32;
   localparam int REC_BITS       = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_INDEX = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRIDE      = CSR_INDEX_BITS'(1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] interval_start;
      logic [31:0] interval_end;
   } ieps_req_type;

   typedef struct packed {
      logic [31:0]         endpoint;
      logic                is_start;
      logic [REC_BITS-1:0] record_index;
      logic                last_event;
      logic                overflow;
   } ieps_rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic                 is_start;
      logic [REC_BITS-1:0]  record;
   } ieps_event_type;

   // broadcast to every cell
   typedef struct packed {
      logic           insert;
      logic           drain;
      ieps_event_type ev;
   } ieps_cmd_type;

   // head of the chain as seen by the controller
   typedef struct packed {
      ieps_event_type head;
      logic           head_valid;
      logic           next_valid;
      logic           full;
   } ieps_status_type;

endpackage

// ----- hw/rtl/ieps_cell.sv -----
// One cell of the sorted event chain.
module ieps_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ieps_pkg::ieps_cmd_type  cmd,
   input  ieps_pkg::ieps_event_type left_data,
   input  logic                    left_valid,
   input  logic                    left_shift,
   input  ieps_pkg::ieps_event_type right_data,
   input  logic                    right_valid,
   output ieps_pkg::ieps_event_type data,
   output logic                    valid,
   output logic                    shift
);
   import ieps_pkg::*;

   ieps_event_type data_ff, data_in;
   logic           valid_ff, valid_in;
   logic           goes_first;
   logic           at_point;

   always_comb begin
      goes_first = (cmd.ev.time_val < data_ff.time_val) ||
                   ((cmd.ev.time_val == data_ff.time_val) && cmd.ev.is_start &&
                    !data_ff.is_start);
      shift    = valid_ff && goes_first;
      at_point = (!valid_ff || goes_first) && left_valid && !left_shift;
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (left_shift) begin
            data_in  = left_data;
            valid_in = 1'b1;
         end else if (at_point) begin
            data_in  = cmd.ev;
            valid_in = 1'b1;
         end
      end else if (cmd.drain) begin
         data_in  = right_data;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

// ----- hw/rtl/ieps_ctrl.sv -----
// Record picking, load sequencing, drain control and result register.
module ieps_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ieps_pkg::ieps_req_type                 req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ieps_pkg::ieps_rsp_type                 rsp_item,
   input  logic                                   csr_we,
   input  logic [ieps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ieps_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  ieps_pkg::ieps_status_type              status,
   output ieps_pkg::ieps_cmd_type                 cmd
);
   import ieps_pkg::*;

   logic [REC_BITS-1:0] first_index_ff, first_index_in;
   logic [REC_BITS-1:0] stride_ff, stride_in;
   logic [REC_BITS-1:0] rec_ff, rec_in;
   logic [REC_BITS-1:0] phase_ff, phase_in;
   logic                overflow_ff, overflow_in;
   logic                pend_ff, pend_in;
   ieps_event_type      pend_ev_ff, pend_ev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ieps_rsp_type        rsp_item_ff, rsp_item_in;

   logic                accept, load, drain, take, pick, want_insert, last;
   logic [REC_BITS-1:0] step;
   logic [REC_BITS:0]   phase_sum;

   always_comb begin
      first_index_in = first_index_ff;
      stride_in      = stride_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_INDEX: first_index_in = csr_wdata[REC_BITS-1:0];
            CSR_STRIDE:      stride_in      = csr_wdata[REC_BITS-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      req_stall   = pend_ff || (rsp_valid_ff && rsp_stall);
      accept      = req_valid && !req_stall;
      load        = accept && (req_item.op == OP_LOAD);
      drain       = accept && (req_item.op == OP_DRAIN);
      take        = load && (rec_ff >= first_index_ff);
      pick        = take && (phase_ff == '0);
      step        = (stride_ff == '0) ? REC_BITS'(1) : stride_ff;
      phase_sum   = {1'b0, phase_ff} + (REC_BITS+1)'(1);
      last        = status.head_valid && !status.next_valid;
      want_insert = pick || pend_ff;

      cmd.insert          = want_insert && !status.full;
      cmd.drain           = drain && status.head_valid;
      cmd.ev.time_val     = TIME_BITS'(req_item.interval_start);
      cmd.ev.is_start     = 1'b1;
      cmd.ev.record       = rec_ff;
      if (pend_ff) begin
         cmd.ev = pend_ev_ff;
      end

      pend_in             = pick;
      pend_ev_in.time_val = TIME_BITS'(req_item.interval_end);
      pend_ev_in.is_start = 1'b0;
      pend_ev_in.record   = rec_ff;

      rec_in      = rec_ff;
      phase_in    = phase_ff;
      overflow_in = overflow_ff;
      if (load) begin
         rec_in = rec_ff + REC_BITS'(1);
      end
      if (take) begin
         phase_in = (phase_sum >= {1'b0, step}) ? '0 : phase_sum[REC_BITS-1:0];
      end
      if (want_insert && status.full) begin
         overflow_in = 1'b1;
      end
      if (cmd.drain && last) begin
         rec_in      = '0;
         phase_in    = '0;
         overflow_in = 1'b0;
      end

      rsp_valid_in             = cmd.drain || (rsp_valid_ff && rsp_stall);
      rsp_item_in              = rsp_item_ff;
      if (cmd.drain) begin
         rsp_item_in.endpoint     = 32'(status.head.time_val);
         rsp_item_in.is_start     = status.head.is_start;
         rsp_item_in.record_index = status.head.record;
         rsp_item_in.last_event   = last;
         rsp_item_in.overflow     = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_index_ff <= '0;
         stride_ff      <= REC_BITS'(1);
         rec_ff         <= '0;
         phase_ff       <= '0;
         overflow_ff    <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_index_ff <= first_index_in;
         stride_ff      <= stride_in;
         rec_ff         <= rec_in;
         phase_ff       <= phase_in;
         overflow_ff    <= overflow_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ev_ff  <= pend_ev_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- hw/rtl/interval_endpoint_event_sorter.sv -----
// Interval endpoint event sorter: top level with the insertion chain of cells.
// A picked load item inserts its start event and then its end event, each in a single pass
// over the whole chain; no new item is taken while the end event is still to be inserted.
// A drain item's result is registered and shows in the cycle after acceptance.
// Items are also held off while a result waits under rsp_stall; MAX_EVENTS cells hold the list.
// Synchronous reset empties the chain and clears counters; registers return to 0 and 1.
module interval_endpoint_event_sorter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ieps_pkg::ieps_req_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ieps_pkg::ieps_rsp_type              rsp_item,
   input  logic                                csr_we,
   input  logic [ieps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ieps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ieps_pkg::*;

   ieps_cmd_type    cmd;
   ieps_status_type status;
   ieps_event_type  cell_data  [MAX_EVENTS];
   logic            cell_valid [MAX_EVENTS];
   logic            cell_shift [MAX_EVENTS];

   ieps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
      ieps_event_type left_data, right_data;
      logic           left_valid, left_shift, right_valid;

      if (i == 0) begin : g_first
         assign left_data  = '0;
         assign left_valid = 1'b1;
         assign left_shift = 1'b0;
      end else begin : g_mid_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_shift = cell_shift[i-1];
      end

      if (i == MAX_EVENTS - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      ieps_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .left_shift  (left_shift),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .shift       (cell_shift[i])
      );
   end

   assign status.head       = cell_data[0];
   assign status.head_valid = cell_valid[0];
   assign status.next_valid = cell_valid[1];
   assign status.full       = cell_valid[MAX_EVENTS-1];

endmodule

// ----- hw/rtl/ieps_checker.sv -----
// Port-level checks of the interval endpoint event sorter, bound to the top level.
`include "interval_endpoint_event_sorter_defines.svh"

module ieps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input ieps_pkg::ieps_req_type req_item,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ieps_pkg::ieps_rsp_type rsp_item
);
   import ieps_pkg::*;

   logic load_acc;
   logic last_out;

   assign load_acc = req_valid && !req_stall && (req_item.op == OP_LOAD);
   assign last_out = rsp_valid && !rsp_stall && rsp_item.last_event;

   `IEPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_item))
   `IEPS_ASSERT_NEXT(a_empty_after_last, clock, reset, last_out, !rsp_valid)
   `IEPS_ASSERT_NEXT(a_load_no_result, clock, reset, load_acc && !rsp_valid, !rsp_valid)
   `IEPS_ASSERT_NOW(a_last_has_valid, clock, reset, rsp_item.last_event && rsp_valid,
      !(req_valid && !req_stall && (req_item.op == OP_DRAIN) && $past(last_out)))

endmodule

bind interval_endpoint_event_sorter ieps_checker u_ieps_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the interval endpoint event sorter.
`timescale 1ns / 1ps

module testbench;
   import ieps_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   typedef struct {
      logic         op;
      logic [31:0]  start_ts;
      logic [31:0]  end_ts;
      bit           typed;
      ieps_rsp_type want;
   } plan_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   ieps_req_type              req_item = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   ieps_rsp_type              rsp_item;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // typed expectation travels with its item
   bit                        req_typed = 1'b0;
   ieps_rsp_type              req_want = '0;

   int                        cycle_count = 0;
   int                        failures = 0;
   int                        burst_left = 0;
   bit                        sending = 1'b0;
   stall_mode_type            stall_mode = STALL_NONE;
   int                        mode_left = 0;

   // predictor state
   ieps_event_type            sorted_events[$];
   ieps_rsp_type              expected_results[$];
   logic [15:0]               next_record;
   logic [15:0]               pick_phase;
   logic                      spill_flag;
   logic [15:0]               first_index_reg;
   logic [15:0]               stride_reg;
   bit                        step_got;
   ieps_rsp_type              step_rsp;
   ieps_rsp_type              want_rsp;

   plan_row_type directed_rows [17] = '{
      '{OP_DRAIN, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
      '{OP_LOAD,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b1, {32'h0000_0000, 1'b1, 16'd0, 1'b0, 1'b0}},
      '{OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, {32'hFFFF_FFFF, 1'b0, 16'd0, 1'b1, 1'b0}},
      '{OP_LOAD,  32'd5,         32'd5,         1'b0, '0},
      '{OP_LOAD,  32'd7,         32'd5,         1'b0, '0},
      '{OP_LOAD,  32'd5,         32'd5,         1'b0, '0},
      '{OP_LOAD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_DRAIN, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{OP_DRAIN, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_DRAIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
   };

   interval_endpoint_event_sorter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void model_reset();
      sorted_events.delete();
      next_record = '0;
      pick_phase = '0;
      spill_flag = 1'b0;
      first_index_reg = 16'd0;
      stride_reg = 16'd1;
   endfunction

   function automatic void model_insert(input logic [31:0] t, input logic s,
                                        input logic [15:0] rec);
      int pos;
      ieps_event_type ev;
      if (sorted_events.size() >= MAX_EVENTS) begin
         spill_flag = 1'b1;
         return;
      end
      pos = 0;
      while (pos < sorted_events.size() &&
             !(t < sorted_events[pos].time_val ||
               (t == sorted_events[pos].time_val && s && !sorted_events[pos].is_start)))
         pos++;
      ev.time_val = t;
      ev.is_start = s;
      ev.record = rec;
      sorted_events.insert(pos, ev);
   endfunction

   function automatic void predict_item(input ieps_req_type it, output bit got,
                                        output ieps_rsp_type r);
      logic [15:0] step_len;
      got = 1'b0;
      r = '0;
      if (it.op == OP_LOAD) begin
         if (next_record >= first_index_reg) begin
            step_len = (stride_reg == 16'd0) ? 16'd1 : stride_reg;
            if (pick_phase == 16'd0) begin
               model_insert(it.interval_start, 1'b1, next_record);
               model_insert(it.interval_end, 1'b0, next_record);
            end
            pick_phase = pick_phase + 16'd1;
            if (pick_phase >= step_len)
               pick_phase = '0;
         end
         next_record = next_record + 16'd1;
      end else if (sorted_events.size() > 0) begin
         got = 1'b1;
         r.endpoint = sorted_events[0].time_val;
         r.is_start = sorted_events[0].is_start;
         r.record_index = sorted_events[0].record;
         r.last_event = (sorted_events.size() == 1);
         r.overflow = spill_flag;
         sorted_events.delete(0);
         if (r.last_event) begin
            next_record = '0;
            pick_phase = '0;
            spill_flag = 1'b0;
         end
      end
   endfunction

   // results are checked before the item accepted at the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         model_reset();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: endpoint %h record_index %h",
                      rsp_item.endpoint, rsp_item.record_index);
               failures++;
            end else begin
               want_rsp = expected_results.pop_front();
               if (rsp_item.endpoint !== want_rsp.endpoint) begin
                  $error("endpoint: expected %h, got %h", want_rsp.endpoint, rsp_item.endpoint);
                  failures++;
               end
               if (rsp_item.is_start !== want_rsp.is_start) begin
                  $error("is_start: expected %b, got %b", want_rsp.is_start, rsp_item.is_start);
                  failures++;
               end
               if (rsp_item.record_index !== want_rsp.record_index) begin
                  $error("record_index: expected %h, got %h",
                         want_rsp.record_index, rsp_item.record_index);
                  failures++;
               end
               if (rsp_item.last_event !== want_rsp.last_event) begin
                  $error("last_event: expected %b, got %b",
                         want_rsp.last_event, rsp_item.last_event);
                  failures++;
               end
               if (rsp_item.overflow !== want_rsp.overflow) begin
                  $error("overflow: expected %b, got %b", want_rsp.overflow, rsp_item.overflow);
                  failures++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_FIRST_INDEX)
               first_index_reg = csr_wdata;
            else if (csr_index == CSR_STRIDE)
               stride_reg = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            predict_item(req_item, step_got, step_rsp);
            if (req_typed)
               expected_results.push_back(req_want);
            else if (step_got)
               expected_results.push_back(step_rsp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 2));
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               rsp_stall <= (cycle_count[3:0] < 4'd6);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [31:0] random_stamp();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3, 4: return $urandom_range(0, 15);
         5, 6: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic ieps_req_type random_item(input logic op);
      ieps_req_type it;
      it.op = op;
      it.interval_start = random_stamp();
      it.interval_end = random_stamp();
      return it;
   endfunction

   task automatic put_item(input ieps_req_type it, input bit typed, input ieps_rsp_type want);
      req_item <= it;
      req_typed <= typed;
      req_want <= want;
      if (!sending)
         req_valid <= 1'b1;
      sending = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         sending = 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // the extra edge lets the monitor book the last accepted item first
   task automatic settle();
      if (sending) begin
         req_valid <= 1'b0;
         sending = 1'b0;
      end
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   // also writes junk to an unused index, which must be ignored
   task automatic set_regs(input logic [15:0] first, input logic [15:0] step);
      csr_we <= 1'b1;
      csr_index <= CSR_FIRST_INDEX;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_STRIDE;
      csr_wdata <= step;
      @(posedge clock);
      csr_index <= CSR_INDEX_BITS'($urandom_range(CSR_STRIDE + 1, 2**CSR_INDEX_BITS - 1));
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_all();
      do
         put_item(random_item(OP_DRAIN), 1'b0, '0);
      while (sorted_events.size() != 0);
   endtask

   task automatic random_build(input int loads);
      int left;
      left = loads;
      while (left > 0) begin
         if ($urandom_range(0, 5) == 0) begin
            put_item(random_item(OP_DRAIN), 1'b0, '0);
         end else begin
            put_item(random_item(OP_LOAD), 1'b0, '0);
            left--;
         end
      end
      if ($urandom_range(0, 2) == 0)
         settle();
      drain_all();
   endtask

   initial begin
      int i;
      ieps_req_type it;
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(directed_rows); i++) begin
         it.op = directed_rows[i].op;
         it.interval_start = directed_rows[i].start_ts;
         it.interval_end = directed_rows[i].end_ts;
         put_item(it, directed_rows[i].typed, directed_rows[i].want);
      end
      settle();

      set_regs(16'd3, 16'd2);
      for (i = 0; i < 3; i++)
         random_build($urandom_range(1, 16));
      settle();

      // zero stride behaves as one
      set_regs(16'd0, 16'd0);
      for (i = 0; i < 3; i++)
         random_build($urandom_range(1, 16));
      settle();

      set_regs(16'd1, 16'd3);
      for (i = 0; i < 3; i++)
         random_build($urandom_range(1, 16));
      settle();

      // fill the store, free one cell, then a start fits and its end is dropped
      set_regs(16'd0, 16'd1);
      for (i = 0; i < MAX_EVENTS / 2; i++)
         put_item(random_item(OP_LOAD), 1'b0, '0);
      put_item(random_item(OP_DRAIN), 1'b0, '0);
      put_item(random_item(OP_LOAD), 1'b0, '0);
      put_item(random_item(OP_LOAD), 1'b0, '0);
      drain_all();
      settle();

      set_regs(16'd0, 16'hFFFF);
      for (i = 0; i < 3; i++)
         random_build($urandom_range(1, 12));
      settle();

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- interval_endpoint_event_sorter.f -----
+incdir+hw/rtl
hw/rtl/ieps_pkg.sv
hw/rtl/ieps_cell.sv
hw/rtl/ieps_ctrl.sv
hw/rtl/interval_endpoint_event_sorter.sv
hw/rtl/ieps_checker.sv
test/testbench.sv
